### rtl/triggered_ramp_generator_defines.svh
// Assertion macros shared by the ramp generator RTL.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef TRIGGERED_RAMP_GENERATOR_DEFINES_SVH
`define TRIGGERED_RAMP_GENERATOR_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define TRG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TRG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/trg_pkg.sv
// Package for the triggered ramp generator: poll type, phase codes,
// register indexes and fixed widths. No dependencies.
`default_nettype none

package trg_pkg;

  localparam int TIME_BITS       = 32;
  localparam int DELAY_BITS      = 24;   // 127 * 100000 fits in 24 bits
  localparam int CFG_INDEX_BITS  = 1;
  localparam int CFG_DATA_BITS   = 7;
  localparam int RAMP_TIME_STEPS = 128;
  localparam int TENTH_US        = 100000;
  localparam int RESET_RAMP_US   = 2 * 1000000;
  localparam int PHASE_BITS      = 2;

  localparam logic [PHASE_BITS-1:0] PH_IDLE = 2'd0;
  localparam logic [PHASE_BITS-1:0] PH_RUN  = 2'd1;
  localparam logic [PHASE_BITS-1:0] PH_DONE = 2'd2;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_INVERT    = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_RAMP_TIME = 1'b1;

  typedef struct packed {
    logic [TIME_BITS-1:0] now_us;
    logic                 trigger_level;
  } poll_t;

endpackage

`default_nettype wire

### rtl/trg_if.sv
// Channel interfaces of the triggered ramp generator: poll input,
// result output and configuration write. Depends on trg_pkg.
`default_nettype none

interface trg_poll_if;
  import trg_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] now_us;
  logic                 trigger_level;
  modport source (output valid, output now_us, output trigger_level, input ready);
  modport sink   (input valid, input now_us, input trigger_level, output ready);
endinterface

interface trg_result_if #(parameter int LEVEL_BITS = 8);
  import trg_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [LEVEL_BITS-1:0] ramp_value;
  logic [PHASE_BITS-1:0] ramp_phase;
  modport source (output valid, output ramp_value, output ramp_phase, input ready);
  modport sink   (input valid, input ramp_value, input ramp_phase, output ready);
endinterface

interface trg_cfg_if;
  import trg_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/triggered_ramp_generator.sv
// Triggered ramp generator top level: input register, step core and result register.
// Depends on trg_pkg, the channel interfaces and the three stage modules.
//
// Usage: each poll beat carries a microsecond timestamp and the trigger level
// and yields exactly one result beat with the level and the phase after the
// update (0 idle, 1 running, 2 finished). Configuration beats on cfg write
// register 0 (invert, which also reloads the idle level) or register 1
// (ramp time in 100 ms units); cfg.ready is always high. Write configuration
// only while no poll is in flight.
// Path: an accepted poll goes through the input register, then the result
// register, before it shows as a valid result.
// Throughput: one poll per cycle while result.ready is high; the step decision is
// a combinational 32-bit subtract and compare plus one level increment or decrement.
// Reset (rst, synchronous): phase idle, level 0, step time 0, ramp time 2 s,
// both registers empty. There is no clearing pass.
// Stall: while the receiver holds result.ready low, the result stays put and
// the input register still takes one more poll if it is empty; then poll.ready drops.
`default_nettype none

module triggered_ramp_generator #(
  parameter int LEVEL_BITS = 8
) (
  input  logic         clk,
  input  logic         rst,
  trg_poll_if.sink     poll,
  trg_result_if.source result,
  trg_cfg_if.sink      cfg
);
  import trg_pkg::*;

  logic                  held_valid;
  poll_t                 held;
  logic                  out_free;
  logic                  advance;
  logic [LEVEL_BITS-1:0] value_next;
  logic [PHASE_BITS-1:0] phase_next;

  // A held poll moves on when the result register can take its result.
  assign advance = held_valid && out_free;

  trg_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .poll       (poll),
    .advance    (advance),
    .held_valid (held_valid),
    .held       (held)
  );

  trg_core #(
    .LEVEL_BITS (LEVEL_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .fire       (advance),
    .poll       (held),
    .value_next (value_next),
    .phase_next (phase_next)
  );

  trg_out_stage #(
    .LEVEL_BITS (LEVEL_BITS)
  ) u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .load       (advance),
    .value_next (value_next),
    .phase_next (phase_next),
    .free       (out_free),
    .result     (result)
  );

endmodule

`default_nettype wire

### rtl/trg_in_stage.sv
// Input register of the ramp generator: captures one poll beat and holds it
// until the core consumes it. Depends on trg_pkg and trg_poll_if.
`default_nettype none

module trg_in_stage (
  input  logic            clk,
  input  logic            rst,
  trg_poll_if.sink        poll,
  input  logic            advance,
  output logic            held_valid,
  output trg_pkg::poll_t  held
);
  import trg_pkg::*;

  logic take;

  // A new beat is taken when the register is empty or drains this cycle.
  assign poll.ready = !held_valid || advance;
  assign take       = poll.valid && poll.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= take || (held_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held.now_us        <= poll.now_us;
      held.trigger_level <= poll.trigger_level;
    end
  end

endmodule

`default_nettype wire

### rtl/trg_core.sv
// Ramp state and step logic: phase, level, step time and the step delay
// derived from the configuration. Depends on trg_pkg, trg_cfg_if and the defines header.
`default_nettype none
`include "triggered_ramp_generator_defines.svh"

module trg_core #(
  parameter int LEVEL_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  trg_cfg_if.sink                        cfg,
  input  logic                           fire,
  input  trg_pkg::poll_t                 poll,
  output logic [LEVEL_BITS-1:0]          value_next,
  output logic [trg_pkg::PHASE_BITS-1:0] phase_next
);
  import trg_pkg::*;

  localparam int LevelMax = (1 << LEVEL_BITS) - 1;
  localparam logic [LEVEL_BITS-1:0] LevelTop = LEVEL_BITS'(LevelMax);
  localparam logic [DELAY_BITS-1:0] ResetDelay = DELAY_BITS'(RESET_RAMP_US / LevelMax);

  logic [PHASE_BITS-1:0] phase;
  logic [LEVEL_BITS-1:0] level;
  logic [LEVEL_BITS-1:0] level_next;
  logic [TIME_BITS-1:0]  last_step_time;
  logic [TIME_BITS-1:0]  last_step_time_next;
  logic [DELAY_BITS-1:0] delay_us;
  logic                  invert;
  logic                  cfg_we;
  logic [TIME_BITS-1:0]  elapsed;
  logic                  due;
  logic [LEVEL_BITS-1:0] idle_level;
  logic [LEVEL_BITS-1:0] new_idle_level;

  // Step delay for every ramp time, worked out at elaboration.
  logic [DELAY_BITS-1:0] delay_rom [RAMP_TIME_STEPS];

  for (genvar g = 0; g < RAMP_TIME_STEPS; g++) begin : g_delay
    assign delay_rom[g] = DELAY_BITS'((g * TENTH_US) / LevelMax);
  end

  assign cfg.ready = 1'b1;
  assign cfg_we    = cfg.valid;

  assign idle_level     = invert ? LevelTop : '0;
  assign new_idle_level = cfg.data[0] ? LevelTop : '0;

  // Elapsed time wraps modulo 2^32 along with the timestamp.
  assign elapsed = poll.now_us - last_step_time;
  assign due     = elapsed >= TIME_BITS'(delay_us);

  always_comb begin
    phase_next          = phase;
    level_next          = level;
    last_step_time_next = last_step_time;
    case (phase)
      PH_RUN: begin
        if (!poll.trigger_level) begin
          phase_next = PH_DONE;
        end else if (due) begin
          if (invert) begin
            if (level == '0) phase_next = PH_DONE;
            else             level_next = level - 1'b1;
          end else begin
            if (level == LevelTop) phase_next = PH_DONE;
            else                   level_next = level + 1'b1;
          end
          last_step_time_next = poll.now_us;
        end
      end
      PH_DONE: begin
        if (!poll.trigger_level) begin
          level_next = idle_level;
          phase_next = PH_IDLE;
        end
      end
      default: begin
        phase_next = poll.trigger_level ? PH_RUN : PH_IDLE;
      end
    endcase
  end

  assign value_next = level_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      level          <= '0;
      last_step_time <= '0;
      delay_us       <= ResetDelay;
      invert         <= 1'b0;
    end else begin
      // Writing the direction reloads the idle level.
      if (cfg_we && cfg.index == CFG_INVERT) begin
        level <= new_idle_level;
      end else if (fire) begin
        level <= level_next;
      end
      if (fire) begin
        phase          <= phase_next;
        last_step_time <= last_step_time_next;
      end
      if (cfg_we) begin
        case (cfg.index)
          CFG_INVERT: begin
            invert <= cfg.data[0];
          end
          CFG_RAMP_TIME: begin
            delay_us <= delay_rom[cfg.data];
          end
          default: begin
          end
        endcase
      end
    end
  end

  `TRG_ASSERT_NEXT(a_trigger_drop, fire && phase == PH_RUN && !poll.trigger_level,
                   phase == PH_DONE, "run did not finish on trigger release")
  `TRG_ASSERT_NEXT(a_hold_state, !fire && !cfg_we,
                   $stable(level) && $stable(phase) && $stable(last_step_time),
                   "state moved without a poll")
  `TRG_ASSERT_NEXT(a_single_step, fire && phase == PH_RUN && !cfg_we,
                   level == $past(level) || level == $past(level) + 1'b1 ||
                   level == $past(level) - 1'b1, "level moved by more than one step")
  `TRG_ASSERT_NOW(a_idle_no_step, fire && phase != PH_RUN,
                  last_step_time_next == last_step_time, "step time changed outside a run")

endmodule

`default_nettype wire

### rtl/trg_out_stage.sv
// Result register of the ramp generator: holds one result beat until the
// receiver takes it. Depends on trg_pkg and trg_result_if.
`default_nettype none

module trg_out_stage #(
  parameter int LEVEL_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  logic [LEVEL_BITS-1:0]          value_next,
  input  logic [trg_pkg::PHASE_BITS-1:0] phase_next,
  output logic                           free,
  trg_result_if.source                   result
);
  import trg_pkg::*;

  logic out_valid;

  assign free         = !out_valid || result.ready;
  assign result.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      result.ramp_value <= value_next;
      result.ramp_phase <= phase_next;
    end
  end

endmodule

`default_nettype wire
